FILE: rtl/mcta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcta_pkg: shared definitions for the tally accumulator
// Operation, status and tally codes, fixed-point widths and the divider
// request and response types.
// ----------------------------------------------------------------------------
package mcta_pkg;

   localparam logic [2:0] FUNC_TRACK     = 3'd0;
   localparam logic [2:0] FUNC_COLLISION = 3'd1;
   localparam logic [2:0] FUNC_CROSSING  = 3'd2;
   localparam logic [2:0] FUNC_BEGIN     = 3'd3;
   localparam logic [2:0] FUNC_END       = 3'd4;
   localparam logic [2:0] FUNC_READ      = 3'd5;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_ALREADY_OPEN = 3'd1;
   localparam logic [2:0] STATUS_NOT_OPEN     = 3'd2;
   localparam logic [2:0] STATUS_RANGE        = 3'd3;
   localparam logic [2:0] STATUS_DIV_ZERO     = 3'd4;

   localparam logic [1:0] TALLY_CURRENT   = 2'd0;
   localparam logic [1:0] TALLY_SURFACE   = 2'd1;
   localparam logic [1:0] TALLY_VOLUME    = 2'd2;
   localparam logic [1:0] TALLY_COLLISION = 2'd3;

   localparam logic [1:0] CSR_GROUPS   = 2'd0;
   localparam logic [1:0] CSR_CELLS    = 2'd1;
   localparam logic [1:0] CSR_SURFACES = 2'd2;

   localparam int HIST_W  = 48;
   localparam int TOTAL_W = 64;
   localparam int SQ_W    = 63;
   localparam int DELTA_W = 49;
   localparam int DIV_W   = 48;

   localparam logic [HIST_W-1:0]  HIST_MAX  = {1'b0, {(HIST_W-1){1'b1}}};
   localparam logic [HIST_W-1:0]  HIST_MIN  = {1'b1, {(HIST_W-1){1'b0}}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
   localparam logic [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
   localparam logic [SQ_W-1:0]    SQ_MAX    = {SQ_W{1'b1}};

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [31:0]      divisor;
      logic             negate;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DELTA_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/mcta_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcta interfaces: request and response channels
// Valid/ready channels carrying one event and one result per beat.
// ----------------------------------------------------------------------------
interface mcta_req_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  func;
   logic        [5:0]  place;
   logic        [2:0]  group;
   logic signed [31:0] weight;
   logic signed [31:0] factor;
   logic        [1:0]  tally;

   modport source (output valid, func, place, group, weight, factor, tally, input ready);
   modport sink   (input valid, func, place, group, weight, factor, tally, output ready);
endinterface

interface mcta_rsp_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  status;
   logic signed [63:0] bin_total;
   logic        [62:0] bin_square_total;
   logic        [31:0] history_count;
   logic               history_open;

   modport source (output valid, status, bin_total, bin_square_total, history_count,
                   history_open, input ready);
   modport sink   (input valid, status, bin_total, bin_square_total, history_count,
                   history_open, output ready);
endinterface
`default_nettype wire

FILE: rtl/mcta_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcta_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/mcta_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcta_div: bit-serial restoring divider
// Divides a 48-bit magnitude by a 32-bit magnitude, one quotient bit per
// cycle, and applies the sign at the end (truncation toward zero).
// ----------------------------------------------------------------------------
module mcta_div import mcta_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff;
   logic             done_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [32:0]      rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [31:0]      dvs_ff;
   logic [32:0]      trial_in;
   logic             fits_in;

   always_comb begin
      trial_in = {rem_ff[31:0], quo_ff[DIV_W-1]};
      fits_in  = trial_in >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W - 1);
            rem_ff  <= '0;
            quo_ff  <= div_req.dividend;
            dvs_ff  <= div_req.divisor;
            neg_ff  <= div_req.negate;
         end else if (busy_ff) begin
            rem_ff <= fits_in ? trial_in - {1'b0, dvs_ff} : trial_in;
            quo_ff <= {quo_ff[DIV_W-2:0], fits_in};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};

endmodule
`default_nettype wire

FILE: rtl/monte_carlo_tally_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// monte_carlo_tally_accumulator: per-history tally bins with running totals
// Scores transport events into history bins and folds them into totals and
// totals of squares at the end of each history.
// ----------------------------------------------------------------------------
// The block takes one request beat at a time and answers each with exactly
// one response beat; req.ready is low from acceptance until the response
// beat has been taken. The memories hold D = 4 * 2^ceil(log2(bins)) words
// (2048 at the default sizes). A track runs one 32x32 multiply, then a
// read-modify-write of the history bin; a collision runs through the
// 48-step bit-serial divider; a crossing scores the current bin, then uses
// the divider for surface flux; a read fetches one total row; begin history
// clears one history word per cycle; end history folds every word through
// one shared multiplier that squares it in three 20x20 partial products.
// After reset the block runs a clearing pass over both memories with
// req.ready low; configuration writes are taken at any time. History
// bins are signed Q32.16, totals signed Q48.16 and totals of squares
// unsigned Q47.16, and every sum saturates. Out-of-range bins and zero
// divisors are reported in the status and score nothing.
// ----------------------------------------------------------------------------
module monte_carlo_tally_accumulator import mcta_pkg::*; #(
   parameter int MAX_CELLS    = 64,
   parameter int MAX_SURFACES = 64,
   parameter int MAX_GROUPS   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mcta_req_if.sink         req,
   mcta_rsp_if.source       rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_data
);

   localparam int PLACE_MAX = (MAX_CELLS > MAX_SURFACES) ? MAX_CELLS : MAX_SURFACES;
   localparam int BIN_DEPTH = PLACE_MAX * MAX_GROUPS;
   localparam int BIN_AW    = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
   localparam int MEM_AW    = BIN_AW + 2;
   localparam int MEM_DEPTH = 1 << MEM_AW;
   localparam int ROW_W     = TOTAL_W + SQ_W;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_MUL, S_MULW, S_DIV, S_HRD, S_HADD, S_WIPE,
      S_FRD, S_FLOAD, S_FM1, S_FM2, S_FM3, S_FM4, S_FWR, S_TRD, S_TCAP, S_RESP
   } state_type;

   state_type          state_ff;
   logic [3:0]         groups_ff;
   logic [6:0]         cells_ff;
   logic [6:0]         surfaces_ff;
   logic               open_ff;
   logic [31:0]        count_ff;
   logic [MEM_AW-1:0]  sweep_ff;
   logic [BIN_AW-1:0]  bin_ff;
   logic [1:0]         tally_sel_ff;
   logic               second_ff;
   logic [31:0]        weight_ff;
   logic [31:0]        factor_ff;
   logic [DELTA_W-1:0] delta_ff;
   logic [2:0]         status_ff;
   logic [TOTAL_W-1:0] bin_total_ff;
   logic [SQ_W-1:0]    bin_sq_ff;
   logic [65:0]        prod_ff;
   logic [79:0]        acc_ff;
   logic [HIST_W-1:0]  h_ff;
   logic [TOTAL_W-1:0] tot_ff;
   logic [SQ_W-1:0]    sq_ff;
   div_req_type        div_req_ff;
   div_rsp_type        div_rsp;

   // Effective configuration, clamped to the synthesized sizes.
   logic [6:0]  g_eff_in;
   logic [6:0]  c_eff_in;
   logic [6:0]  s_eff_in;
   logic        cell_ok_in;
   logic        surf_ok_in;
   logic [15:0] bin_full_in;
   logic [31:0] wmag_in;
   logic [31:0] fmag_in;

   always_comb begin
      g_eff_in = (int'(groups_ff) > MAX_GROUPS) ? 7'(MAX_GROUPS) : {3'b0, groups_ff};
      c_eff_in = (int'(cells_ff) > MAX_CELLS) ? 7'(MAX_CELLS) : cells_ff;
      s_eff_in = (int'(surfaces_ff) > MAX_SURFACES) ? 7'(MAX_SURFACES) : surfaces_ff;
      cell_ok_in = ({4'b0, req.group} < g_eff_in) && ({1'b0, req.place} < c_eff_in);
      surf_ok_in = ({4'b0, req.group} < g_eff_in) && ({1'b0, req.place} < s_eff_in);
      bin_full_in = 16'(req.group) + 16'(g_eff_in) * 16'(req.place);
      wmag_in = req.weight[31] ? 32'(-req.weight) : 32'(req.weight);
      fmag_in = req.factor[31] ? 32'(-req.factor) : 32'(req.factor);
   end

   // Memories: history words and {total, total of squares} rows, addressed
   // by {tally, bin}.
   logic              hist_we;
   logic [MEM_AW-1:0] hist_waddr;
   logic [HIST_W-1:0] hist_wdata;
   logic [MEM_AW-1:0] rd_addr;
   logic [HIST_W-1:0] hist_rdata;
   logic              tot_we;
   logic [MEM_AW-1:0] tot_waddr;
   logic [ROW_W-1:0]  tot_wdata;
   logic [ROW_W-1:0]  tot_rdata;

   mcta_ram #(.WIDTH(HIST_W), .DEPTH(MEM_DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (rd_addr),
      .rd_data (hist_rdata)
   );

   mcta_ram #(.WIDTH(ROW_W), .DEPTH(MEM_DEPTH)) u_total_ram (
      .clock   (clock),
      .wr_en   (tot_we),
      .wr_addr (tot_waddr),
      .wr_data (tot_wdata),
      .rd_addr (rd_addr),
      .rd_data (tot_rdata)
   );

   mcta_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   // The shared multiplier: the track product, or one partial product of
   // a square during the fold.
   logic [HIST_W-1:0]  hmag_in;
   logic signed [32:0] mul_a_in;
   logic signed [32:0] mul_b_in;

   always_comb begin
      hmag_in = h_ff[HIST_W-1] ? -h_ff : h_ff;
      unique case (state_ff)
         S_FM1: begin
            mul_a_in = {13'b0, hmag_in[19:0]};
            mul_b_in = {13'b0, hmag_in[19:0]};
         end
         S_FM2: begin
            mul_a_in = {13'b0, hmag_in[39:20]};
            mul_b_in = {13'b0, hmag_in[19:0]};
         end
         S_FM3: begin
            mul_a_in = {13'b0, hmag_in[39:20]};
            mul_b_in = {13'b0, hmag_in[39:20]};
         end
         default: begin
            mul_a_in = {weight_ff[31], weight_ff};
            mul_b_in = {factor_ff[31], factor_ff};
         end
      endcase
   end

   // Saturating adders for scoring and folding.
   logic [49:0]        hsum_in;
   logic [HIST_W-1:0]  hsat_in;
   logic [64:0]        tsum_in;
   logic [TOTAL_W-1:0] tsat_in;
   logic               sq_big_in;
   logic [SQ_W-1:0]    q_in;
   logic [63:0]        ssum_in;
   logic [SQ_W-1:0]    ssat_in;

   always_comb begin
      hsum_in = {{2{hist_rdata[HIST_W-1]}}, hist_rdata} + {delta_ff[DELTA_W-1], delta_ff};
      if (hsum_in[49:47] == 3'b000 || hsum_in[49:47] == 3'b111) begin
         hsat_in = hsum_in[HIST_W-1:0];
      end else begin
         hsat_in = hsum_in[49] ? HIST_MIN : HIST_MAX;
      end
      tsum_in = {tot_ff[TOTAL_W-1], tot_ff} + {{17{h_ff[HIST_W-1]}}, h_ff};
      if (tsum_in[64] == tsum_in[63]) begin
         tsat_in = tsum_in[TOTAL_W-1:0];
      end else begin
         tsat_in = tsum_in[64] ? TOTAL_MIN : TOTAL_MAX;
      end
      // A magnitude of 2^40 or more squares beyond the 63-bit range.
      sq_big_in = hmag_in[HIST_W-1:40] != '0;
      q_in = (sq_big_in || acc_ff[79]) ? SQ_MAX : acc_ff[78:16];
      ssum_in = {1'b0, sq_ff} + {1'b0, q_in};
      ssat_in = ssum_in[63] ? SQ_MAX : ssum_in[SQ_W-1:0];
   end

   // Memory port steering.
   always_comb begin
      hist_we    = 1'b0;
      hist_waddr = {tally_sel_ff, bin_ff};
      hist_wdata = hsat_in;
      tot_we     = 1'b0;
      tot_waddr  = sweep_ff;
      tot_wdata  = {tsat_in, ssat_in};
      rd_addr    = (state_ff == S_FRD) ? sweep_ff : {tally_sel_ff, bin_ff};
      unique case (state_ff)
         S_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = sweep_ff;
            hist_wdata = '0;
            tot_we     = 1'b1;
            tot_wdata  = '0;
         end
         S_WIPE: begin
            hist_we    = 1'b1;
            hist_waddr = sweep_ff;
            hist_wdata = '0;
         end
         S_HADD: begin
            hist_we = 1'b1;
         end
         S_FWR: begin
            tot_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         groups_ff   <= 4'd8;
         cells_ff    <= 7'd64;
         surfaces_ff <= 7'd64;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GROUPS:   groups_ff   <= csr_data[3:0];
            CSR_CELLS:    cells_ff    <= csr_data;
            CSR_SURFACES: surfaces_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a_in * mul_b_in;
      if (reset) begin
         state_ff         <= S_CLEAR;
         sweep_ff         <= '0;
         open_ff          <= 1'b0;
         count_ff         <= '0;
         div_req_ff.start <= 1'b0;
      end else begin
         div_req_ff.start <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (&sweep_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req.valid) begin
                  status_ff    <= STATUS_OK;
                  bin_total_ff <= '0;
                  bin_sq_ff    <= '0;
                  bin_ff       <= bin_full_in[BIN_AW-1:0];
                  weight_ff    <= req.weight;
                  factor_ff    <= req.factor;
                  second_ff    <= 1'b0;
                  sweep_ff     <= '0;
                  state_ff     <= S_RESP;
                  unique case (req.func)
                     FUNC_TRACK: begin
                        if (!cell_ok_in) begin
                           status_ff <= STATUS_RANGE;
                        end else begin
                           tally_sel_ff <= TALLY_VOLUME;
                           state_ff     <= S_MUL;
                        end
                     end
                     FUNC_COLLISION: begin
                        if (!cell_ok_in) begin
                           status_ff <= STATUS_RANGE;
                        end else if (req.factor == '0) begin
                           status_ff <= STATUS_DIV_ZERO;
                        end else begin
                           tally_sel_ff        <= TALLY_COLLISION;
                           div_req_ff.start    <= 1'b1;
                           div_req_ff.dividend <= {wmag_in, 16'b0};
                           div_req_ff.divisor  <= fmag_in;
                           div_req_ff.negate   <= req.weight[31] ^ req.factor[31];
                           state_ff            <= S_DIV;
                        end
                     end
                     FUNC_CROSSING: begin
                        if (!surf_ok_in) begin
                           status_ff <= STATUS_RANGE;
                        end else if (req.factor == '0) begin
                           status_ff <= STATUS_DIV_ZERO;
                        end else begin
                           // Current first, then surface flux through the divider.
                           tally_sel_ff        <= TALLY_CURRENT;
                           delta_ff            <= {{17{req.weight[31]}}, req.weight};
                           second_ff           <= 1'b1;
                           div_req_ff.dividend <= {wmag_in, 16'b0};
                           div_req_ff.divisor  <= fmag_in;
                           div_req_ff.negate   <= req.weight[31];
                           state_ff            <= S_HRD;
                        end
                     end
                     FUNC_BEGIN: begin
                        if (open_ff) begin
                           status_ff <= STATUS_ALREADY_OPEN;
                        end else begin
                           open_ff  <= 1'b1;
                           state_ff <= S_WIPE;
                        end
                     end
                     FUNC_END: begin
                        if (!open_ff) begin
                           status_ff <= STATUS_NOT_OPEN;
                        end else begin
                           open_ff <= 1'b0;
                           if (count_ff != '1) begin
                              count_ff <= count_ff + 1'b1;
                           end
                           state_ff <= S_FRD;
                        end
                     end
                     FUNC_READ: begin
                        if (!((req.tally < TALLY_VOLUME) ? surf_ok_in : cell_ok_in)) begin
                           status_ff <= STATUS_RANGE;
                        end else begin
                           tally_sel_ff <= req.tally;
                           state_ff     <= S_TRD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_MUL: begin
               state_ff <= S_MULW;
            end
            S_MULW: begin
               // Arithmetic shift of the product floors it to Q.16.
               delta_ff <= {prod_ff[63], prod_ff[63:16]};
               state_ff <= S_HRD;
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  delta_ff <= div_rsp.quotient;
                  state_ff <= S_HRD;
               end
            end
            S_HRD: begin
               state_ff <= S_HADD;
            end
            S_HADD: begin
               if (second_ff) begin
                  second_ff        <= 1'b0;
                  tally_sel_ff     <= TALLY_SURFACE;
                  div_req_ff.start <= 1'b1;
                  state_ff         <= S_DIV;
               end else begin
                  state_ff <= S_RESP;
               end
            end
            S_WIPE: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (&sweep_ff) begin
                  state_ff <= S_RESP;
               end
            end
            S_FRD: begin
               state_ff <= S_FLOAD;
            end
            S_FLOAD: begin
               h_ff     <= hist_rdata;
               tot_ff   <= tot_rdata[ROW_W-1:SQ_W];
               sq_ff    <= tot_rdata[SQ_W-1:0];
               state_ff <= S_FM1;
            end
            S_FM1: begin
               state_ff <= S_FM2;
            end
            S_FM2: begin
               acc_ff   <= {40'b0, prod_ff[39:0]};
               state_ff <= S_FM3;
            end
            S_FM3: begin
               acc_ff   <= acc_ff + {18'b0, prod_ff[40:0], 21'b0};
               state_ff <= S_FM4;
            end
            S_FM4: begin
               acc_ff   <= acc_ff + {prod_ff[39:0], 40'b0};
               state_ff <= S_FWR;
            end
            S_FWR: begin
               sweep_ff <= sweep_ff + 1'b1;
               state_ff <= (&sweep_ff) ? S_RESP : S_FRD;
            end
            S_TRD: begin
               state_ff <= S_TCAP;
            end
            S_TCAP: begin
               bin_total_ff <= tot_rdata[ROW_W-1:SQ_W];
               bin_sq_ff    <= tot_rdata[SQ_W-1:0];
               state_ff     <= S_RESP;
            end
            S_RESP: begin
               if (rsp.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req.ready            = state_ff == S_IDLE;
   assign rsp.valid            = state_ff == S_RESP;
   assign rsp.status           = status_ff;
   assign rsp.bin_total        = bin_total_ff;
   assign rsp.bin_square_total = bin_sq_ff;
   assign rsp.history_count    = count_ff;
   assign rsp.history_open     = open_ff;

endmodule
`default_nettype wire

FILE: rtl/mcta_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcta_checker: port-level checks for the tally accumulator
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module mcta_checker import mcta_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [63:0] rsp_bin_total,
   input wire logic [62:0] rsp_bin_square_total,
   input wire logic        rsp_history_open
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped before it was taken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("new request taken while a response is pending");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_bin_total == '0 && rsp_bin_square_total == '0)
      else $error("failed request returned bin data");

   a_second_begin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ALREADY_OPEN |-> rsp_history_open)
      else $error("second begin reported with no history open");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during the clearing pass");

endmodule

bind monte_carlo_tally_accumulator mcta_checker u_mcta_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req.ready),
   .rsp_valid            (rsp.valid),
   .rsp_ready            (rsp.ready),
   .rsp_status           (rsp.status),
   .rsp_bin_total        (rsp.bin_total),
   .rsp_bin_square_total (rsp.bin_square_total),
   .rsp_history_open     (rsp.history_open)
);
`default_nettype wire

FILE: test/monte_carlo_tally_accumulator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// monte_carlo_tally_accumulator_tb: self-checking bench for the tally engine
// Drives histories of scoring events, reads and error cases through the
// request channel under several bin configurations. A scoreboard predicts
// every response beat and compares it field by field.
// ----------------------------------------------------------------------------
module monte_carlo_tally_accumulator_tb;
   import mcta_pkg::*;

   localparam int  BINS      = 512;
   localparam int  CYCLE_CAP = 4000000;
   localparam int  DRAIN     = 20;

   typedef struct {
      logic        [2:0]  func;
      logic        [5:0]  place;
      logic        [2:0]  group;
      logic signed [31:0] weight;
      logic signed [31:0] factor;
      logic        [1:0]  tally;
   } event_beat_type;

   typedef struct {
      logic        [2:0]  status;
      logic signed [63:0] bin_total;
      logic        [62:0] bin_square_total;
      logic        [31:0] history_count;
      logic               history_open;
   } result_beat_type;

   // Scoreboard: keeps its own copy of every bin and of the configuration,
   // predicts one result per accepted event beat and checks results in order.
   class tally_scoreboard;
      longint          cur_hist[BINS], surf_hist[BINS], vol_hist[BINS], coll_hist[BINS];
      longint          cur_sum[BINS], surf_sum[BINS], vol_sum[BINS], coll_sum[BINS];
      logic [62:0]     cur_sq[BINS], surf_sq[BINS], vol_sq[BINS], coll_sq[BINS];
      bit              open_flag;
      int unsigned     done_count;
      int unsigned     groups, cells, surfaces;
      result_beat_type awaited[$];
      int              mismatches;

      function new();
         groups = 8;
         cells = 64;
         surfaces = 64;
         open_flag = 0;
         done_count = 0;
         mismatches = 0;
         foreach (cur_hist[i]) begin
            cur_hist[i] = 0; surf_hist[i] = 0; vol_hist[i] = 0; coll_hist[i] = 0;
            cur_sum[i] = 0; surf_sum[i] = 0; vol_sum[i] = 0; coll_sum[i] = 0;
            cur_sq[i] = 0; surf_sq[i] = 0; vol_sq[i] = 0; coll_sq[i] = 0;
         end
      endfunction

      function void set_reg(logic [1:0] idx, logic [6:0] value);
         if (idx == CSR_GROUPS) groups = value[3:0];
         else if (idx == CSR_CELLS) cells = value;
         else if (idx == CSR_SURFACES) surfaces = value;
      endfunction

      // Saturating add into a Q32.16 history bin.
      function longint hist_add(longint a, longint d);
         longint lim, s;
         lim = (longint'(1) <<< 47) - 1;
         s = a + d;
         if (s > lim) s = lim;
         if (s < -lim - 1) s = -lim - 1;
         return s;
      endfunction

      // Square of a Q32.16 value, floored to Q.16, saturated to 63 bits.
      function logic [62:0] square16(longint h);
         logic [127:0] m, p;
         m = (h < 0) ? 128'(-h) : 128'(h);
         p = (m * m) >> 16;
         return (p > 128'(SQ_MAX)) ? SQ_MAX : p[62:0];
      endfunction

      function void fold(ref longint hist[BINS], ref longint tot[BINS],
                         ref logic [62:0] sq[BINS]);
         logic signed [64:0] s;
         logic [63:0]        q;
         for (int i = 0; i < BINS; i++) begin
            s = 65'(signed'(tot[i])) + 65'(signed'(hist[i]));
            if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) tot[i] = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (s < -65'sh0_8000_0000_0000_0000) tot[i] = 64'sh8000_0000_0000_0000;
            else tot[i] = s[63:0];
            q = 64'(sq[i]) + 64'(square16(hist[i]));
            sq[i] = (q > 64'(SQ_MAX)) ? SQ_MAX : q[62:0];
         end
      endfunction

      function void note(event_beat_type t);
         result_beat_type r;
         int unsigned     g_eff, c_eff, s_eff, k;
         bit              cell_ok, surf_ok, ok;
         longint          w, f;
         g_eff = (groups > 8) ? 8 : groups;
         c_eff = (cells > 64) ? 64 : cells;
         s_eff = (surfaces > 64) ? 64 : surfaces;
         k = t.group + g_eff * t.place;
         cell_ok = (t.group < g_eff) && (t.place < c_eff);
         surf_ok = (t.group < g_eff) && (t.place < s_eff);
         w = t.weight;
         f = t.factor;
         r.status = STATUS_OK;
         r.bin_total = 0;
         r.bin_square_total = 0;
         case (t.func)
            FUNC_TRACK: begin
               if (!cell_ok) r.status = STATUS_RANGE;
               else vol_hist[k] = hist_add(vol_hist[k], (w * f) >>> 16);
            end
            FUNC_COLLISION: begin
               if (!cell_ok) r.status = STATUS_RANGE;
               else if (f == 0) r.status = STATUS_DIV_ZERO;
               else coll_hist[k] = hist_add(coll_hist[k], (w * 65536) / f);
            end
            FUNC_CROSSING: begin
               if (!surf_ok) r.status = STATUS_RANGE;
               else if (f == 0) r.status = STATUS_DIV_ZERO;
               else begin
                  cur_hist[k] = hist_add(cur_hist[k], w);
                  surf_hist[k] = hist_add(surf_hist[k], (w * 65536) / ((f < 0) ? -f : f));
               end
            end
            FUNC_BEGIN: begin
               if (open_flag) r.status = STATUS_ALREADY_OPEN;
               else begin
                  open_flag = 1;
                  foreach (cur_hist[i]) begin
                     cur_hist[i] = 0; surf_hist[i] = 0; vol_hist[i] = 0; coll_hist[i] = 0;
                  end
               end
            end
            FUNC_END: begin
               if (!open_flag) r.status = STATUS_NOT_OPEN;
               else begin
                  open_flag = 0;
                  if (done_count != 32'hFFFF_FFFF) done_count++;
                  fold(cur_hist, cur_sum, cur_sq);
                  fold(surf_hist, surf_sum, surf_sq);
                  fold(vol_hist, vol_sum, vol_sq);
                  fold(coll_hist, coll_sum, coll_sq);
               end
            end
            FUNC_READ: begin
               ok = (t.tally < 2) ? surf_ok : cell_ok;
               if (!ok) r.status = STATUS_RANGE;
               else case (t.tally)
                  TALLY_CURRENT:   begin r.bin_total = cur_sum[k];  r.bin_square_total = cur_sq[k];  end
                  TALLY_SURFACE:   begin r.bin_total = surf_sum[k]; r.bin_square_total = surf_sq[k]; end
                  TALLY_VOLUME:    begin r.bin_total = vol_sum[k];  r.bin_square_total = vol_sq[k];  end
                  TALLY_COLLISION: begin r.bin_total = coll_sum[k]; r.bin_square_total = coll_sq[k]; end
               endcase
            end
            default: ;
         endcase
         r.history_count = done_count;
         r.history_open = open_flag;
         awaited.push_back(r);
      endfunction

      function void check(result_beat_type got);
         result_beat_type exp;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: result beat with nothing awaited");
            return;
         end
         exp = awaited.pop_front();
         if (got.status !== exp.status || got.bin_total !== exp.bin_total ||
             got.bin_square_total !== exp.bin_square_total ||
             got.history_count !== exp.history_count ||
             got.history_open !== exp.history_open) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: exp st=%0d tot=%0h sq=%0h cnt=%0d open=%0b, got st=%0d tot=%0h sq=%0h cnt=%0d open=%0b",
                        exp.status, exp.bin_total, exp.bin_square_total, exp.history_count,
                        exp.history_open, got.status, got.bin_total, got.bin_square_total,
                        got.history_count, got.history_open);
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       csr_write_enable = 0;
   logic [1:0] csr_index = CSR_GROUPS;
   logic [6:0] csr_data = '0;
   bit         calm = 0;
   int         cycles = 0;

   mcta_req_if req_bus ();
   mcta_rsp_if rsp_bus ();

   tally_scoreboard sb = new();

   monte_carlo_tally_accumulator u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus.sink),
      .rsp              (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #6 clock = ~clock;

   // Watchdog. The slowest legal run is dominated by the end-history fold
   // and stays far below this cap.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 0;
      req_bus.func = FUNC_READ;
      req_bus.place = 0;
      req_bus.group = 0;
      req_bus.weight = 0;
      req_bus.factor = 0;
      req_bus.tally = TALLY_CURRENT;
      rsp_bus.ready = 0;
   end

   // Result side: a random stall before every beat, none in calm stretches.
   initial begin
      int              stall;
      result_beat_type got;
      @(negedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_bus.ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.status = rsp_bus.status;
         got.bin_total = rsp_bus.bin_total;
         got.bin_square_total = rsp_bus.bin_square_total;
         got.history_count = rsp_bus.history_count;
         got.history_open = rsp_bus.history_open;
         sb.check(got);
         @(negedge clock);
      end
   end

   // Sends one event beat, with a random gap first; the beat is noted in
   // the scoreboard at the edge where it is accepted.
   task automatic send(event_beat_type t);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.func <= t.func;
      req_bus.place <= t.place;
      req_bus.group <= t.group;
      req_bus.weight <= t.weight;
      req_bus.factor <= t.factor;
      req_bus.tally <= t.tally;
      do @(posedge clock); while (!req_bus.ready);
      sb.note(t);
      @(negedge clock);
   endtask

   task automatic ev(logic [2:0] func, logic [5:0] place, logic [2:0] group,
                     logic [31:0] weight, logic [31:0] factor, logic [1:0] tally);
      event_beat_type t;
      t.func = func;
      t.place = place;
      t.group = group;
      t.weight = weight;
      t.factor = factor;
      t.tally = tally;
      send(t);
   endtask

   // An event whose other fields are all random.
   task automatic ev_noise(logic [2:0] func);
      ev(func, 6'($urandom()), 3'($urandom()), $urandom(), $urandom(), 2'($urandom()));
   endtask

   // Registers are only written with nothing outstanding; every event gives
   // a result, so an empty expectation queue means the block is idle.
   task automatic set_bins(logic [6:0] g, logic [6:0] c, logic [6:0] s);
      req_bus.valid <= 0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= CSR_GROUPS;   csr_data <= g; @(negedge clock);
      sb.set_reg(CSR_GROUPS, g);
      csr_index <= CSR_CELLS;    csr_data <= c; @(negedge clock);
      sb.set_reg(CSR_CELLS, c);
      csr_index <= CSR_SURFACES; csr_data <= s; @(negedge clock);
      sb.set_reg(CSR_SURFACES, s);
      csr_write_enable <= 0;
   endtask

   function automatic logic [31:0] rand_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return $urandom();
      if (pick < 8) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      if (pick == 8) return 32'h7FFF_FFFF;
      return 32'h8000_0000;
   endfunction

   // Index draws stay mostly inside the configured bins, with some strays
   // anywhere in the field to hit the range check.
   function automatic logic [5:0] rand_place(int unsigned lim);
      if (lim == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
      return 6'($urandom_range(0, (lim > 64 ? 64 : lim) - 1));
   endfunction

   function automatic logic [2:0] rand_group();
      int unsigned g;
      g = (sb.groups > 8) ? 8 : sb.groups;
      if (g == 0 || $urandom_range(0, 9) == 0) return 3'($urandom_range(0, 7));
      return 3'($urandom_range(0, g - 1));
   endfunction

   task automatic random_score();
      int          pick;
      logic [2:0]  func;
      logic [31:0] f;
      pick = $urandom_range(0, 19);
      f = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_value();
      if (pick < 5)
         ev(FUNC_TRACK, rand_place(sb.cells), rand_group(), rand_value(), f,
            2'($urandom()));
      else if (pick < 10)
         ev(FUNC_COLLISION, rand_place(sb.cells), rand_group(), rand_value(), f,
            2'($urandom()));
      else if (pick < 17)
         ev(FUNC_CROSSING, rand_place(sb.surfaces), rand_group(), rand_value(), f,
            2'($urandom()));
      else if (pick == 17)
         ev_noise(FUNC_BEGIN);
      else begin
         // Noise: reads in mid-history and the unused function codes.
         func = (pick == 18) ? FUNC_READ : 3'($urandom_range(6, 7));
         ev_noise(func);
      end
   endtask

   task automatic random_read();
      logic [1:0] tal;
      tal = 2'($urandom_range(0, 3));
      ev(FUNC_READ, rand_place(tal < 2 ? sb.surfaces : sb.cells), rand_group(),
         $urandom(), $urandom(), tal);
   endtask

   task automatic run_phase(int histories);
      int n;
      for (int h = 0; h < histories; h++) begin
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0) random_score();
         ev_noise(FUNC_BEGIN);
         n = $urandom_range(18, 28);
         repeat (n) random_score();
         ev_noise(FUNC_END);
         if ($urandom_range(0, 4) == 0)
            ev_noise(FUNC_END);
         repeat (4) random_read();
      end
      calm = 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part at the reset configuration.
      ev(FUNC_END, 0, 0, 0, 0, TALLY_CURRENT);                         // end with none open
      ev(FUNC_BEGIN, 0, 0, 0, 0, TALLY_CURRENT);
      ev(FUNC_BEGIN, 63, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TALLY_COLLISION); // second begin
      ev(FUNC_TRACK, 63, 7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, TALLY_CURRENT);
      ev(FUNC_TRACK, 63, 7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, TALLY_CURRENT);
      ev(FUNC_TRACK, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, TALLY_CURRENT);
      ev(FUNC_TRACK, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, TALLY_CURRENT);
      ev(FUNC_COLLISION, 5, 3, 32'h0001_0000, 32'd0, TALLY_CURRENT);   // zero sigma
      ev(FUNC_COLLISION, 5, 3, 32'h8000_0000, 32'd1, TALLY_CURRENT);
      ev(FUNC_COLLISION, 5, 3, 32'h7FFF_FFFF, 32'h8000_0000, TALLY_CURRENT);
      ev(FUNC_CROSSING, 9, 1, 32'h0002_0000, 32'd0, TALLY_CURRENT);    // zero ordinate
      ev(FUNC_CROSSING, 9, 1, 32'h0002_0000, 32'hFFFF_8000, TALLY_CURRENT);
      ev(FUNC_CROSSING, 9, 1, 32'h8000_0000, 32'h8000_0000, TALLY_CURRENT);
      ev(3'd6, 1, 1, 1, 1, TALLY_SURFACE);
      ev(3'd7, 2, 2, 2, 2, TALLY_VOLUME);
      ev(FUNC_END, 0, 0, 0, 0, TALLY_CURRENT);
      ev(FUNC_READ, 63, 7, 0, 0, TALLY_VOLUME);
      ev(FUNC_READ, 0, 0, 0, 0, TALLY_VOLUME);
      ev(FUNC_READ, 5, 3, 0, 0, TALLY_COLLISION);
      ev(FUNC_READ, 9, 1, 0, 0, TALLY_CURRENT);
      ev(FUNC_READ, 9, 1, 0, 0, TALLY_SURFACE);
      ev(FUNC_TRACK, 4, 2, 32'h0003_0000, 32'h0002_0000, TALLY_CURRENT); // no history open

      // Out-of-range indices, and one in-range surface read, under a narrow configuration.
      set_bins(7'd2, 7'd3, 7'd4);
      ev(FUNC_TRACK, 3, 0, 32'h0001_0000, 32'h0001_0000, TALLY_CURRENT);
      ev(FUNC_CROSSING, 0, 2, 32'h0001_0000, 32'h0001_0000, TALLY_CURRENT);
      ev(FUNC_READ, 3, 1, 0, 0, TALLY_SURFACE);
      ev(FUNC_READ, 3, 1, 0, 0, TALLY_VOLUME);

      // Random phases across the configuration extremes.
      set_bins(7'd1, 7'd1, 7'd1);         run_phase(7);
      set_bins(7'd15, 7'd127, 7'd127);    run_phase(8);
      set_bins(7'd0, 7'd0, 7'd0);         run_phase(2);
      set_bins(7'd8, 7'd64, 7'd64);       run_phase(8);
      set_bins(7'd5, 7'd37, 7'd20);       run_phase(7);
      set_bins(7'($urandom_range(1, 8)), 7'($urandom_range(1, 64)),
               7'($urandom_range(1, 64)));
      run_phase(6);

      req_bus.valid <= 0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/mcta_pkg.sv
rtl/mcta_if.sv
rtl/mcta_ram.sv
rtl/mcta_div.sv
rtl/monte_carlo_tally_accumulator.sv
rtl/mcta_checker.sv
test/monte_carlo_tally_accumulator_tb.sv
